@@ rtl/delimited_field_splitter_core_macros.svh @@
// Assertion macros shared by the delimited field splitter modules.
`ifndef DELIMITED_FIELD_SPLITTER_CORE_MACROS_SVH
`define DELIMITED_FIELD_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define DFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dfs_pkg.sv @@
// Types and constants shared by the delimited field splitter modules.
`timescale 1ns / 1ps

package dfs_pkg;

    localparam int DFS_NUM_DELIMS = 4;
    localparam int DFS_CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [DFS_CFG_INDEX_W-1:0] CFG_DELIMITER_COUNT = 3'd0;
    localparam logic [DFS_CFG_INDEX_W-1:0] CFG_DELIMITER_0     = 3'd1;
    localparam logic [DFS_CFG_INDEX_W-1:0] CFG_DELIMITER_1     = 3'd2;
    localparam logic [DFS_CFG_INDEX_W-1:0] CFG_DELIMITER_2     = 3'd3;
    localparam logic [DFS_CFG_INDEX_W-1:0] CFG_DELIMITER_3     = 3'd4;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [7:0] RESET_DELIM_0 = CH_COMMA;
    localparam logic [7:0] RESET_DELIM_1 = CH_SPACE;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } dfs_kind_t;

    typedef enum logic [4:0] {
        MODE_SKIP   = 5'b00001,
        MODE_PLAIN  = 5'b00010,
        MODE_QUOTED = 5'b00100,
        MODE_AFTER  = 5'b01000,
        MODE_HALTED = 5'b10000
    } dfs_mode_t;

    typedef struct packed {
        dfs_kind_t   kind;
        logic [7:0]  field_byte;
        logic [15:0] error_position;
        logic        last_of_run;
    } dfs_res_t;

    // Everything one input word yields: up to two results and the next state
    typedef struct packed {
        logic [1:0] count;
        dfs_res_t   res0;
        dfs_res_t   res1;
        dfs_mode_t  mode_next;
        logic       dq_next;
    } dfs_step_t;

endpackage

@@ rtl/delimited_field_splitter_core.sv @@
// Top level of the delimited field splitter: state, configuration and channels.
`timescale 1ns / 1ps
`include "delimited_field_splitter_core_macros.svh"

// Byte-serial splitter for delimited text with optional quoting.
// Input channel s_*: one string byte per word in s_tdata, s_tlast on the final
// byte of a string. Output channel m_*: one result per word; m_tuser gives the
// kind (field byte, end of field, parse error), m_tdata carries the field byte
// and the error position, m_tlast marks the last result a byte caused. A byte
// yields zero, one or two results.
// Configuration channel cfg_*: index 0 is the delimiter count (0 means comma
// and space), indexes 1 to 4 the delimiter bytes. Write only while idle;
// cfg_ready is always high.
// Results are registered in the result queue before they appear on m_*, in order.
// Throughput: one byte per cycle while s_tready is high; a byte with two results
// gives the output two results to pass, so the three-entry result queue may fill
// and drop s_tready until the receiver catches up.
// When m_tready is low, results are held in the queue and s_tready falls once
// no room is left for a further byte.
// Reset: parser back to skipping leading blanks at position 0, delimiters to
// comma and space, queue empty. No clearing pass is needed.
module delimited_field_splitter_core
    import dfs_pkg::*;
#(
    parameter int MAX_DELIMITERS = 4,
    parameter int POSITION_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] char_in
    input  logic                        s_tlast,    // end_of_string
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,    // [7:0] field_byte, [23:8] error_position
    output logic [1:0]                  m_tuser,    // [1:0] kind
    output logic                        m_tlast,    // last_of_run
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [DFS_CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                  cfg_data
);

    dfs_mode_t                        mode_reg;
    logic                             dq_reg;
    logic [POSITION_WIDTH-1:0]        pos_reg;
    logic [POSITION_WIDTH-1:0]        pos_next;
    logic [2:0]                       delim_count_reg;
    logic [DFS_NUM_DELIMS-1:0][7:0]   delim_reg;
    dfs_step_t                        step;
    dfs_res_t                         head;
    logic                             in_fire;
    logic                             cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_tvalid && s_tready;

    // Decide this byte's results and the next parse mode
    dfs_step_logic #(
        .MAX_DELIMITERS (MAX_DELIMITERS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_step (
        .char_in         (s_tdata),
        .end_of_string   (s_tlast),
        .mode            (mode_reg),
        .open_dq         (dq_reg),
        .position        (pos_reg),
        .delimiter_count (delim_count_reg),
        .delims          (delim_reg),
        .step            (step)
    );

    // Hold results until the receiver takes them
    dfs_out_buf u_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .res_count  (step.count),
        .res0       (step.res0),
        .res1       (step.res1),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {head.error_position, head.field_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

    // Position wraps at its width and rewinds at the end of each string
    assign pos_next = s_tlast ? '0 : pos_reg + POSITION_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SKIP;
            dq_reg   <= 1'b0;
            pos_reg  <= '0;
        end
        else if (in_fire)
        begin
            mode_reg <= step.mode_next;
            dq_reg   <= step.dq_next;
            pos_reg  <= pos_next;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_count_reg <= 3'd0;
            delim_reg[0]    <= RESET_DELIM_0;
            delim_reg[1]    <= RESET_DELIM_1;
            delim_reg[2]    <= 8'd0;
            delim_reg[3]    <= 8'd0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_DELIMITER_COUNT: delim_count_reg <= cfg_data[2:0];
                CFG_DELIMITER_0:     delim_reg[0]    <= cfg_data;
                CFG_DELIMITER_1:     delim_reg[1]    <= cfg_data;
                CFG_DELIMITER_2:     delim_reg[2]    <= cfg_data;
                CFG_DELIMITER_3:     delim_reg[3]    <= cfg_data;
                default:             delim_count_reg <= delim_count_reg;
            endcase
        end
    end

    `DFS_ASSERT_NOW(a_halted_silent, in_fire && mode_reg == MODE_HALTED, step.count == 2'd0, "halted parser produced a result")
    `DFS_ASSERT_NEXT(a_eos_rewinds, in_fire && s_tlast, mode_reg == MODE_SKIP && pos_reg == '0 && !dq_reg, "end of string did not rewind")
    `DFS_ASSERT_NOW(a_last_marks, in_fire && step.count == 2'd2, !step.res0.last_of_run && step.res1.last_of_run, "last marker misplaced")

endmodule

@@ rtl/dfs_step_logic.sv @@
// Per-byte tokenizer decision: results and next parse state for one word.
`timescale 1ns / 1ps

module dfs_step_logic
    import dfs_pkg::*;
#(
    parameter int MAX_DELIMITERS = 4,
    parameter int POSITION_WIDTH = 16
)
(
    input  logic [7:0]                       char_in,
    input  logic                             end_of_string,
    input  dfs_mode_t                        mode,
    input  logic                             open_dq,
    input  logic [POSITION_WIDTH-1:0]        position,
    input  logic [2:0]                       delimiter_count,
    input  logic [DFS_NUM_DELIMS-1:0][7:0]   delims,
    output dfs_step_t                        step
);

    localparam int LIMIT = (MAX_DELIMITERS < DFS_NUM_DELIMS) ? MAX_DELIMITERS
                                                               : DFS_NUM_DELIMS;

    function automatic logic in_set(input logic [7:0] c, input logic [2:0] n,
                                    input logic [DFS_NUM_DELIMS-1:0][7:0] d);
        logic hit;
        hit = 1'b0;
        if (n == 3'd0)
        begin
            hit = (c == CH_COMMA) || (c == CH_SPACE);
        end
        else
        begin
            for (int i = 0; i < DFS_NUM_DELIMS; i++)
            begin
                if ((3'(i) < n) && (d[i] == c))
                begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    logic [2:0]                  eff_count;
    logic                        c_delim;
    logic                        tab_delim;
    logic                        sp_delim;
    logic                        blank;
    logic                        opens_quote;
    logic                        plain_delim;
    logic                        adds_empty;
    logic [7:0]                  quote_char;
    logic [POSITION_WIDTH+15:0]  pos_ext;

    always_comb
    begin
        eff_count   = (delimiter_count > 3'(LIMIT)) ? 3'(LIMIT) : delimiter_count;
        c_delim     = in_set(char_in, eff_count, delims);
        tab_delim   = in_set(CH_TAB, eff_count, delims);
        sp_delim    = in_set(CH_SPACE, eff_count, delims);
        blank       = (char_in == CH_SPACE) || ((char_in == CH_TAB) && !tab_delim);
        opens_quote = ((char_in == CH_SQUOTE) || (char_in == CH_DQUOTE)) && !c_delim;
        // tab splits an unquoted field whenever space does
        plain_delim = c_delim || (sp_delim && (char_in == CH_TAB));
        // a trailing non-blank delimiter leaves an empty field behind it
        adds_empty  = end_of_string && (char_in != CH_SPACE) && (char_in != CH_TAB);
        quote_char  = open_dq ? CH_DQUOTE : CH_SQUOTE;
        pos_ext     = {16'd0, position};

        step.count     = 2'd0;
        step.res0      = '{kind: KIND_END, default: '0};
        step.res1      = '{kind: KIND_END, default: '0};
        step.mode_next = mode;
        step.dq_next   = open_dq;

        case (mode)
            MODE_SKIP:
            begin
                if (blank)
                begin
                    step.count = end_of_string ? 2'd1 : 2'd0;
                end
                else if (opens_quote)
                begin
                    step.dq_next   = (char_in == CH_DQUOTE);
                    step.mode_next = MODE_QUOTED;
                    step.count     = end_of_string ? 2'd1 : 2'd0;
                end
                else if (plain_delim)
                begin
                    step.count     = adds_empty ? 2'd2 : 2'd1;
                    step.mode_next = MODE_SKIP;
                end
                else
                begin
                    step.res0.kind       = KIND_BYTE;
                    step.res0.field_byte = char_in;
                    step.count           = end_of_string ? 2'd2 : 2'd1;
                    step.mode_next       = MODE_PLAIN;
                end
            end
            MODE_PLAIN:
            begin
                if (plain_delim)
                begin
                    step.count     = adds_empty ? 2'd2 : 2'd1;
                    step.mode_next = MODE_SKIP;
                end
                else
                begin
                    step.res0.kind       = KIND_BYTE;
                    step.res0.field_byte = char_in;
                    step.count           = end_of_string ? 2'd2 : 2'd1;
                end
            end
            MODE_QUOTED:
            begin
                if (char_in == quote_char)
                begin
                    step.mode_next = MODE_AFTER;
                    step.count     = end_of_string ? 2'd1 : 2'd0;
                end
                else
                begin
                    step.res0.kind       = KIND_BYTE;
                    step.res0.field_byte = char_in;
                    step.count           = end_of_string ? 2'd2 : 2'd1;
                end
            end
            MODE_AFTER:
            begin
                if (!sp_delim && blank)
                begin
                    step.count = end_of_string ? 2'd1 : 2'd0;
                end
                else if (c_delim)
                begin
                    step.count     = adds_empty ? 2'd2 : 2'd1;
                    step.mode_next = MODE_SKIP;
                end
                else
                begin
                    step.res0.kind           = KIND_ERROR;
                    step.res0.error_position = pos_ext[15:0];
                    step.count               = 2'd1;
                    step.mode_next           = MODE_HALTED;
                end
            end
            default:
            begin
                step.mode_next = MODE_HALTED;
            end
        endcase

        step.res0.last_of_run = (step.count == 2'd1);
        step.res1.last_of_run = (step.count == 2'd2);

        // end of string always rewinds the parser
        if (end_of_string)
        begin
            step.mode_next = MODE_SKIP;
            step.dq_next   = 1'b0;
        end
    end

endmodule

@@ rtl/dfs_out_buf.sv @@
// Three-entry result queue between the tokenizer and the output channel.
`timescale 1ns / 1ps
`include "delimited_field_splitter_core_macros.svh"

module dfs_out_buf
    import dfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  logic [1:0] res_count,
    input  dfs_res_t   res0,
    input  dfs_res_t   res1,
    output logic       head_valid,
    input  logic       head_ready,
    output dfs_res_t   head
);

    localparam int DEPTH = 3;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dfs_res_t             ent_reg  [DEPTH];
    dfs_res_t             ent_sh   [DEPTH];
    dfs_res_t             ent_next [DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     base;
    logic [CNT_W:0]       fill_sum;
    logic                 pop;
    logic                 push;

    always_comb
    begin
        pop        = (count_reg != '0) && head_ready;
        base       = count_reg - CNT_W'(pop);
        push_ready = (base <= CNT_W'(DEPTH - 2));
        push       = push_valid && push_ready;
        fill_sum   = {1'b0, base} + (push ? (CNT_W + 1)'(res_count) : '0);
        count_next = fill_sum[CNT_W-1:0];

        ent_sh[DEPTH-1] = ent_reg[DEPTH-1];
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            ent_sh[i] = pop ? ent_reg[i+1] : ent_reg[i];
        end

        for (int i = 0; i < DEPTH; i++)
        begin
            ent_next[i] = ent_sh[i];
            if (push && (res_count != 2'd0) && (CNT_W'(i) == base))
            begin
                ent_next[i] = res0;
            end
            if (push && (res_count == 2'd2) && (CNT_W'(i) == base + CNT_W'(1)))
            begin
                ent_next[i] = res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = ent_reg[0];

    `DFS_ASSERT_NOW(a_no_overflow, push, fill_sum <= (CNT_W + 1)'(DEPTH), "result queue overflow")
    `DFS_ASSERT_NOW(a_empty_accepts, count_reg == '0, push_ready, "empty queue refused a word")
    `DFS_ASSERT_NEXT(a_drains, pop && count_reg == CNT_W'(1) && (!push || res_count == 2'd0), count_reg == '0, "queue failed to drain")

endmodule
